FILE: sv/shbs_pkg.sv
// ----------------------------------------------------------------------------
// shbs_pkg
// Shared types and constants of the string hash bucket select block.
// ----------------------------------------------------------------------------
package shbs_pkg;

    // Hash mode codes
    localparam logic [2:0] MODE_ZERO  = 3'd0;
    localparam logic [2:0] MODE_FIRST = 3'd1;
    localparam logic [2:0] MODE_LEN   = 3'd2;
    localparam logic [2:0] MODE_SUM   = 3'd3;
    localparam logic [2:0] MODE_ROL   = 3'd4;
    localparam logic [2:0] MODE_ELF   = 3'd5;

    // Register map (word index on the APB port)
    localparam logic REG_HASH_MODE    = 1'b0;
    localparam logic REG_BUCKET_COUNT = 1'b1;

    localparam int          ADDR_W            = 3;
    localparam logic [2:0]  HASH_MODE_RESET   = MODE_ELF;
    localparam logic [15:0] BUCKET_CNT_RESET  = 16'd1024;

    // Field widths
    localparam int HASH_W   = 64;
    localparam int BUCKET_W = 16;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 32;

    // ELF/PJW fold nibble position (bits 59:56 of the hash)
    localparam int ELF_TOP_LSB = 56;

    // Default depth of the request queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // One finished key on its way to the bucket divider
    typedef struct packed {
        logic [HASH_W-1:0]   hash;
        logic [BUCKET_W-1:0] divisor;
    } shbs_req_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } shbs_state_t;

endpackage

FILE: sv/string_hash_bucket_select.sv
// ----------------------------------------------------------------------------
// string_hash_bucket_select
// Streaming 64-bit string hash with bucket index selection.
// ----------------------------------------------------------------------------
// Usage:
//   Key bytes enter on in_valid/in_stall/key_byte, one request per byte; a zero
//   byte ends the key. Each terminator produces one result request on
//   out_valid/out_stall with hash_value and bucket_index (hash modulo
//   bucket_count, 0 when bucket_count is 0). Other bytes produce nothing.
//   Non-terminator bytes are taken one per cycle while the queue is not full.
//   A terminator hands the hash to a queue; the bucket divider works one hash
//   bit per cycle and takes a new hash only once its result is taken, so it sets
//   the key rate once the queue has filled. in_stall rises while the queue is
//   full. While out_stall is high the result holds and the divider waits; the
//   front keeps hashing bytes until the queue fills. hash_mode and bucket_count
//   are written over APB (offsets 0x0 and 0x4); the user must write them only
//   while the block is idle, which the block does not enforce. Reset clears the
//   key state and queue and loads hash_mode 5 (ELF) and bucket_count 1024.
// ----------------------------------------------------------------------------
module string_hash_bucket_select #(
    parameter int QUEUE_DEPTH = shbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shbs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // key bytes
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    key_byte,
    // results
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   bucket_index,
    output logic [63:0]                   hash_value
);
    import shbs_pkg::*;

    logic [2:0]           mode_reg, mode_next;
    logic [BUCKET_W-1:0]  buckets_reg, buckets_next;
    logic                 cfg_write;
    logic                 reg_sel;

    shbs_req_t            push_data;
    shbs_req_t            head_data;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[2];

    always_comb
    begin
        mode_next    = mode_reg;
        buckets_next = buckets_reg;
        if (cfg_write) begin
            unique case (reg_sel)
                REG_HASH_MODE:    mode_next    = pwdata[2:0];
                REG_BUCKET_COUNT: buckets_next = pwdata[BUCKET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_HASH_MODE:    prdata = {29'd0, mode_reg};
            REG_BUCKET_COUNT: prdata = {16'd0, buckets_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= HASH_MODE_RESET;
            buckets_reg <= BUCKET_CNT_RESET;
        end else begin
            mode_reg    <= mode_next;
            buckets_reg <= buckets_next;
        end
    end

    // Hashing front
    shbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_byte     (key_byte),
        .hash_mode    (mode_reg),
        .bucket_count (buckets_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_data)
    );

    // Request queue
    shbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Bucket divider
    shbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (head_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bucket_index (bucket_index),
        .hash_value   (hash_value)
    );

endmodule

FILE: sv/shbs_front.sv
// ----------------------------------------------------------------------------
// shbs_front
// Takes key bytes, updates the running hash, and on a terminator pushes the
// finished hash and the bucket count into the request queue.
// ----------------------------------------------------------------------------
module shbs_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               key_byte,
    input  logic [2:0]               hash_mode,
    input  logic [15:0]              bucket_count,
    input  logic                     q_full,
    output logic                     q_push,
    output shbs_pkg::shbs_req_t      q_data
);
    import shbs_pkg::*;

    logic [HASH_W-1:0]  acc_reg, acc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  first_reg, first_next;

    logic               accept;
    logic               is_term;
    logic               is_first;
    logic [HASH_W-1:0]  byte_ext;
    logic [HASH_W-1:0]  elf_sum;
    logic [HASH_W-1:0]  elf_top;
    logic [HASH_W-1:0]  final_hash;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_term  = (key_byte == '0);
    assign is_first = (count_reg == '0);
    assign byte_ext = {{(HASH_W-BYTE_W){1'b0}}, key_byte};

    // ELF/PJW step: shift, add, fold bits 59:56 back into the low bits
    assign elf_sum = {acc_reg[HASH_W-5:0], 4'b0000} + byte_ext;
    assign elf_top = elf_sum & {{(HASH_W-ELF_TOP_LSB-4){1'b0}}, 4'hF, {ELF_TOP_LSB{1'b0}}};

    // Hash of the completed key, by the mode in force at the terminator
    always_comb
    begin
        case (hash_mode) inside
            MODE_ZERO:  final_hash = '0;
            MODE_FIRST: final_hash = {{(HASH_W-BYTE_W){1'b0}}, first_reg};
            MODE_LEN:   final_hash = {{(HASH_W-COUNT_W){1'b0}}, count_reg};
            MODE_SUM, MODE_ROL, MODE_ELF: final_hash = acc_reg;
            default:    final_hash = '0;
        endcase
    end

    // Key state update
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        first_next = first_reg;
        if (accept) begin
            if (is_term) begin
                acc_next   = '0;
                count_next = '0;
                first_next = '0;
            end else begin
                if (is_first) begin
                    first_next = key_byte;
                end
                case (hash_mode)
                    MODE_SUM: acc_next = acc_reg + byte_ext;
                    MODE_ROL:
                    begin
                        if (!is_first) begin
                            acc_next = {acc_reg[HASH_W-2:0], acc_reg[HASH_W-1]} ^ byte_ext;
                        end
                    end
                    MODE_ELF:
                    begin
                        acc_next = (elf_sum ^ (elf_top >> ELF_TOP_LSB)) & ~elf_top;
                    end
                    default: acc_next = acc_reg;
                endcase
                // saturating length count
                if (count_reg != '1) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    assign q_push         = accept && is_term;
    assign q_data.hash    = final_hash;
    assign q_data.divisor = bucket_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg   <= '0;
            count_reg <= '0;
            first_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

endmodule

FILE: sv/shbs_queue.sv
// ----------------------------------------------------------------------------
// shbs_queue
// Small request queue between the hashing front and the bucket divider.
// ----------------------------------------------------------------------------
module shbs_queue #(
    parameter int DEPTH = shbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  shbs_pkg::shbs_req_t      push_data,
    input  logic                     pop,
    output shbs_pkg::shbs_req_t      head_data,
    output logic                     full,
    output logic                     empty
);
    import shbs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    shbs_req_t       mem [DEPTH];
    shbs_req_t       head_reg;
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = head_reg;

    // Pointer and fill count update, wrapping at any depth
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage; the head entry is read ahead into a register, with the
    // incoming request forwarded when it lands at the new head
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wptr_reg] <= push_data;
        end
        if (do_push && (wptr_reg == rptr_next)) begin
            head_reg <= push_data;
        end else begin
            head_reg <= mem[rptr_next];
        end
    end

endmodule

FILE: sv/shbs_back.sv
// ----------------------------------------------------------------------------
// shbs_back
// Bucket divider: takes one request from the queue, reduces the hash modulo
// the bucket count one bit per cycle, then holds the result for the receiver.
// ----------------------------------------------------------------------------
module shbs_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  shbs_pkg::shbs_req_t      q_data,
    input  logic                     q_empty,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [15:0]              bucket_index,
    output logic [63:0]              hash_value
);
    import shbs_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    shbs_state_t          state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [HASH_W-1:0]    hash_reg, hash_next;
    logic [HASH_W-1:0]    dvd_reg, dvd_next;
    logic [BUCKET_W-1:0]  div_reg, div_next;
    logic [BUCKET_W-1:0]  rem_reg, rem_next;

    logic                 load;
    logic                 div_step;
    logic [BUCKET_W:0]    trial;
    logic [BUCKET_W:0]    trial_sub;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_DIV;
            ST_DIV:  if (step_reg == '0) state_next = ST_HOLD;
            ST_HOLD: if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        load      = 1'b0;
        div_step  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: load      = !q_empty;
            ST_DIV:  div_step  = 1'b1;
            ST_HOLD: out_valid = 1'b1;
            default: ;
        endcase
    end

    assign q_pop = load;

    // Restoring remainder step, most significant dividend bit first
    assign trial     = {rem_reg, dvd_reg[HASH_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb
    begin
        step_next = step_reg;
        hash_next = hash_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (load) begin
            hash_next = q_data.hash;
            dvd_next  = q_data.hash;
            div_next  = q_data.divisor;
            rem_next  = '0;
            step_next = STEP_W'(HASH_W-1);
        end else if (div_step) begin
            dvd_next  = {dvd_reg[HASH_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial_sub[BUCKET_W-1:0];
            end else begin
                rem_next = trial[BUCKET_W-1:0];
            end
        end
    end

    assign bucket_index = (div_reg == '0) ? '0 : rem_reg;
    assign hash_value   = hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

endmodule
